// File: design/dcrm_pkg.sv
// Shared types and constants for the changed-cell rectangle merger.
// No dependencies; imported by dcrm_ctrl and dirty_cell_rectangle_merger.
package dcrm_pkg;

    localparam int COLS_DEF = 32;
    localparam int ROWS_DEF = 24;

    // printable range that marks a cell
    localparam logic [7:0] CODE_MIN = 8'd32;
    localparam logic [7:0] CODE_MAX = 8'd127;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TAKE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WR,
        S_SCAN,
        S_FIND,
        S_DOWN,
        S_SHIFT,
        S_COUNT,
        S_MASK,
        S_CLR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       found;
        logic [4:0] x;
        logic [4:0] y;
        logic [5:0] w;
        logic [4:0] h;
    } t_rect;

endpackage

// File: design/dcrm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dcrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/dcrm_ctrl.sv
// Sequencer for the merger: marks cells, scans the row memory, grows the
// rectangle and clears it. Depends on dcrm_pkg; drives one dcrm_ram.
module dcrm_ctrl
    import dcrm_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_func,
    input  logic [4:0]              i_col,
    input  logic [4:0]              i_row,
    input  logic [7:0]              i_code,
    output logic                    o_stall,
    output logic                    o_res_valid,
    output t_rect                   o_res,
    input  logic                    i_res_ready,
    output logic                    o_we,
    output logic [$clog2(ROWS)-1:0] o_waddr,
    output logic [COLS-1:0]         o_wdata,
    output logic                    o_re,
    output logic [$clog2(ROWS)-1:0] o_raddr,
    input  logic [COLS-1:0]         i_rdata
);

    localparam int CW = $clog2(COLS);
    localparam int RW = $clog2(ROWS);
    localparam int WW = $clog2(COLS + 1);
    localparam int HW = $clog2(ROWS + 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    t_state          r_state, n_state;
    logic [ROWS-1:0] r_valid, n_valid;
    logic [RW-1:0]   r_row, n_row;
    logic [RW-1:0]   r_y, n_y;
    logic [RW-1:0]   r_ylast, n_ylast;
    logic [CW-1:0]   r_x, n_x;
    logic [WW-1:0]   r_w, n_w;
    logic [HW-1:0]   r_h, n_h;
    logic            r_found, n_found;
    logic [COLS-1:0] r_acc, n_acc;
    logic [COLS-1:0] r_mask, n_mask;

    logic [COLS-1:0] rd;
    logic [COLS-1:0] col_bit;
    logic [CW-1:0]   first_set;
    logic [WW-1:0]   run_len;
    logic [COLS-1:0] rect_mask;
    logic            mark_ok;

    // rows never written read as zero
    assign rd = r_valid[r_row] ? i_rdata : '0;

    assign mark_ok = (i_code >= CODE_MIN) && (i_code <= CODE_MAX)
                  && (7'(i_col) < 7'(COLS)) && (7'(i_row) < 7'(ROWS));

    always_comb begin
        col_bit = '0;
        for (int j = 0; j < COLS; j++) begin
            col_bit[j] = (CW'(j) == r_x);
        end
    end

    always_comb begin
        first_set = '0;
        for (int i = COLS - 1; i >= 0; i--) begin
            if (r_acc[i]) begin
                first_set = CW'(i);
            end
        end
    end

    // trailing ones of the shifted column AND
    always_comb begin
        run_len = WW'(COLS);
        for (int i = COLS - 1; i >= 0; i--) begin
            if (!r_acc[i]) begin
                run_len = WW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < COLS; i++) begin
            rect_mask[i] = (i >= int'(r_x)) && (i < int'(r_x) + int'(r_w));
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_row   = r_row;
        n_y     = r_y;
        n_ylast = r_ylast;
        n_x     = r_x;
        n_w     = r_w;
        n_h     = r_h;
        n_found = r_found;
        n_acc   = r_acc;
        n_mask  = r_mask;
        o_we    = 1'b0;
        o_waddr = r_row;
        o_wdata = '0;
        o_re    = 1'b0;
        o_raddr = r_row;
        o_stall = 1'b1;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_func == FUNC_TAKE) begin
                        n_found = 1'b0;
                        n_x     = '0;
                        n_y     = '0;
                        n_w     = '0;
                        n_h     = '0;
                        n_row   = '0;
                        o_re    = 1'b1;
                        o_raddr = '0;
                        n_state = S_SCAN;
                    end else if (mark_ok) begin
                        n_row   = RW'(i_row);
                        n_x     = CW'(i_col);
                        o_re    = 1'b1;
                        o_raddr = RW'(i_row);
                        n_state = S_WR;
                    end
                end
            end
            S_WR: begin
                o_we    = 1'b1;
                o_wdata = rd | col_bit;
                n_valid[r_row] = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (rd != '0) begin
                    n_found = 1'b1;
                    n_y     = r_row;
                    n_ylast = r_row;
                    n_acc   = rd;
                    n_state = S_FIND;
                end else if (r_row == LAST_ROW) begin
                    n_state = S_DONE;
                end else begin
                    n_row   = r_row + 1'b1;
                    o_re    = 1'b1;
                    o_raddr = r_row + 1'b1;
                end
            end
            S_FIND: begin
                n_x = first_set;
                n_h = HW'(1);
                if (r_y == LAST_ROW) begin
                    n_state = S_SHIFT;
                end else begin
                    n_row   = r_y + 1'b1;
                    o_re    = 1'b1;
                    o_raddr = r_y + 1'b1;
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                if (rd[r_x]) begin
                    n_acc   = r_acc & rd;
                    n_h     = r_h + 1'b1;
                    n_ylast = r_row;
                    if (r_row == LAST_ROW) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_row   = r_row + 1'b1;
                        o_re    = 1'b1;
                        o_raddr = r_row + 1'b1;
                    end
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_acc   = r_acc >> r_x;
                n_state = S_COUNT;
            end
            S_COUNT: begin
                n_w     = run_len;
                n_state = S_MASK;
            end
            S_MASK: begin
                n_mask  = rect_mask;
                n_row   = r_y;
                o_re    = 1'b1;
                o_raddr = r_y;
                n_state = S_CLR;
            end
            S_CLR: begin
                o_we    = 1'b1;
                o_wdata = rd & ~r_mask;
                n_valid[r_row] = 1'b1;
                if (r_row == r_ylast) begin
                    n_state = S_DONE;
                end else begin
                    n_row   = r_row + 1'b1;
                    o_re    = 1'b1;
                    o_raddr = r_row + 1'b1;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.found = r_found;
    assign o_res.x     = 5'(r_x);
    assign o_res.y     = 5'(r_y);
    assign o_res.w     = 6'(r_w);
    assign o_res.h     = 5'(r_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_y     <= n_y;
        r_ylast <= n_ylast;
        r_x     <= n_x;
        r_w     <= n_w;
        r_h     <= n_h;
        r_found <= n_found;
        r_acc   <= n_acc;
        r_mask  <= n_mask;
    end

endmodule

// File: design/dirty_cell_rectangle_merger.sv
// Changed-cell rectangle merger: a write request marks one screen cell when its
// code is printable (32..127) and the cell lies inside the map; a take request
// returns and clears the first changed rectangle in row-major order, or found=0
// when nothing is marked. The map lives in a ROWS x COLS row memory read and
// written one row a cycle. A marking write reads the row and writes it back with
// the cell set; an ignored write leaves the map as it is. A take scans rows to
// the first marked one, grows the rectangle down, finds its width, then reads
// and clears its rows through the single memory read port. Reset clears the map
// at once through per-row valid bits. One result waits in the output register
// while new requests are taken. Depends on dcrm_pkg, dcrm_ctrl and dcrm_ram.
module dirty_cell_rectangle_merger
    import dcrm_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [4:0] i_col,
    input  logic [4:0] i_row,
    input  logic [7:0] i_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_found,
    output logic [4:0] o_rect_x,
    output logic [4:0] o_rect_y,
    output logic [5:0] o_rect_width,
    output logic [4:0] o_rect_height
);

    localparam int RW = $clog2(ROWS);

    logic            we, re;
    logic [RW-1:0]   waddr, raddr;
    logic [COLS-1:0] wdata, rdata;
    logic            res_valid, res_ready;
    t_rect           res;

    logic            r_ovalid, n_ovalid;
    t_rect           r_out, n_out;

    dcrm_ctrl #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_code      (i_code),
        .o_stall     (o_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    dcrm_ram #(
        .WIDTH(COLS),
        .DEPTH(ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register takes a new result when empty or when its result is taken
    assign res_ready = !r_ovalid || !i_stall;

    always_comb begin
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        if (res_valid && res_ready) begin
            n_ovalid = 1'b1;
            n_out    = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid       = r_ovalid;
    assign o_found       = r_out.found;
    assign o_rect_x      = r_out.x;
    assign o_rect_y      = r_out.y;
    assign o_rect_width  = r_out.w;
    assign o_rect_height = r_out.h;

endmodule
